/* sv/tqma_pkg.sv */
// Shared types and codes for the two-queue message arbiter.
package tqma_pkg;

    localparam int ENTITY_W  = 16;
    localparam int KIND_W    = 8;
    localparam int PAYLOAD_W = 32;

    localparam logic [1:0] MODE_PUSH     = 2'd0;
    localparam logic [1:0] MODE_PUSH_DEF = 2'd1;
    localparam logic [1:0] MODE_POP      = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DROPPED   = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE = 8'hFF;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [KIND_W-1:0]    kind;
        logic [ENTITY_W-1:0]  entity;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

/* sv/tqma_queue.sv */
// Linear message queue with a prefetched head entry.
module tqma_queue #(
    parameter int DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tqma_pkg::q_ctrl_t ctrl,
    input  tqma_pkg::entry_t  wr_entry,
    output tqma_pkg::q_stat_t stat,
    output tqma_pkg::entry_t  head_entry
);
    import tqma_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = $clog2(DEPTH + 1);

    entry_t        mem [DEPTH];
    entry_t        head_entry_reg;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] head_inc;
    logic          last;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign head_inc = head_reg + PW'(1);
    assign last     = (head_inc == tail_reg);

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctrl.pop) begin
            if (last) begin
                head_next = '0;
                tail_next = '0;
            end else begin
                head_next = head_inc;
            end
        end else if (ctrl.push) begin
            tail_next = tail_reg + PW'(1);
        end
    end

    // head never reaches DEPTH while the queue holds anything
    assign rd_addr = head_next[AW-1:0];
    assign wr_addr = tail_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // registered read of the next head, with bypass of a push into an empty queue
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[wr_addr] <= wr_entry;
        end
        if (ctrl.push && wr_addr == rd_addr) begin
            head_entry_reg <= wr_entry;
        end else begin
            head_entry_reg <= mem[rd_addr];
        end
    end

    assign stat.empty = (tail_reg == '0);
    assign stat.full  = (tail_reg == PW'(DEPTH));
    assign head_entry = head_entry_reg;

endmodule

/* sv/two_queue_message_arbiter.sv */
// Top level: two linear message queues with type-aware pop arbitration.
//
//  channel | dir | signals                    | transfer
//  --------+-----+----------------------------+---------------------------------
//  s_      | in  | tvalid tready tdata tuser  | one push or pop command
//  m_      | out | tvalid tready tdata        | one result for every command
//
// One command per cycle sustained while m_tready stays high; each passes through the
// input register, then the result register. The decision and the queue update
// happen in the same cycle, reading each queue's head from a prefetch register.
// Reset empties both queues and clears the processing type; store contents are
// left as they are. A stalled m_ side holds the result and s_tready drops
// once the input register is also occupied.
module two_queue_message_arbiter #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // lock[0], entity_id[16:1], msg_kind[24:17], payload[56:25]
    input  logic [1:0]  s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // out_valid[0], out_entity[16:1], out_kind[24:17],
                                  // out_payload[56:25], from_queue[57], status[59:58]
);
    import tqma_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  in_mode_reg;
    logic        in_lock_reg;
    entry_t      in_entry_reg;
    logic        fire;
    logic        s_accept;

    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg, m_tdata_next;

    logic [KIND_W-1:0] cur_kind_reg, cur_kind_next;

    q_ctrl_t d_ctrl, i_ctrl;
    q_stat_t d_stat, i_stat;
    entry_t  d_head, i_head;

    logic        res_valid;
    entry_t      res_entry;
    logic        res_src;
    logic [1:0]  res_status;

    assign fire     = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg         <= s_tuser;
            in_lock_reg         <= s_tdata[0];
            in_entry_reg.entity <= s_tdata[16:1];
            in_entry_reg.kind   <= s_tdata[24:17];
            in_entry_reg.payload <= s_tdata[56:25];
        end
    end

    tqma_queue #(.DEPTH(QUEUE_DEPTH)) u_deferred (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (d_ctrl),
        .wr_entry   (in_entry_reg),
        .stat       (d_stat),
        .head_entry (d_head)
    );

    tqma_queue #(.DEPTH(QUEUE_DEPTH)) u_immediate (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (i_ctrl),
        .wr_entry   (in_entry_reg),
        .stat       (i_stat),
        .head_entry (i_head)
    );

    always_comb begin
        d_ctrl        = '0;
        i_ctrl        = '0;
        cur_kind_next = cur_kind_reg;
        res_valid     = 1'b0;
        res_entry     = '0;
        res_src       = 1'b0;
        res_status    = ST_OK;
        if (fire) begin
            unique case (in_mode_reg) inside
                MODE_PUSH, MODE_PUSH_DEF: begin
                    if (in_mode_reg == MODE_PUSH && in_lock_reg) begin
                        if (i_stat.full) begin
                            res_status = ST_DROPPED;
                        end else begin
                            i_ctrl.push = 1'b1;
                        end
                    end else begin
                        if (d_stat.full) begin
                            res_status = ST_DROPPED;
                        end else begin
                            d_ctrl.push = 1'b1;
                        end
                    end
                end
                MODE_POP: begin
                    if (i_stat.empty) begin
                        if (d_stat.empty) begin
                            res_status = ST_POP_EMPTY;
                        end else begin
                            d_ctrl.pop    = 1'b1;
                            cur_kind_next = d_head.kind;
                        end
                    end else if (!d_stat.empty && d_head.kind != cur_kind_reg) begin
                        d_ctrl.pop = 1'b1;
                    end else begin
                        i_ctrl.pop = 1'b1;
                    end
                    if (d_ctrl.pop) begin
                        res_valid = 1'b1;
                        res_entry = d_head;
                    end else if (i_ctrl.pop) begin
                        res_valid = 1'b1;
                        res_entry = i_head;
                        res_src   = 1'b1;
                    end
                end
                default: begin
                    // unused mode: no state change, empty result
                end
            endcase
        end
    end

    always_comb begin
        m_tdata_next        = '0;
        m_tdata_next[0]     = res_valid;
        m_tdata_next[16:1]  = res_entry.entity;
        m_tdata_next[24:17] = res_entry.kind;
        m_tdata_next[56:25] = res_entry.payload;
        m_tdata_next[57]    = res_src;
        m_tdata_next[59:58] = res_status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            cur_kind_reg <= KIND_NONE;
        end else begin
            cur_kind_reg <= cur_kind_next;
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // at most one queue moves per command
    a_one_queue_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({d_ctrl.push, d_ctrl.pop, i_ctrl.push, i_ctrl.pop}) <= 1)
        else $error("more than one queue operation in a cycle");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !((d_ctrl.push && d_stat.full) || (i_ctrl.push && i_stat.full)))
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !((d_ctrl.pop && d_stat.empty) || (i_ctrl.pop && i_stat.empty)))
        else $error("pop from an empty queue");

    // a fired command always leaves a result in the output register
    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_tvalid_reg)
        else $error("result lost after command");

endmodule

/* test/two_queue_message_arbiter_test.sv */
// Self-checking testbench for the two-queue message arbiter: directed rows, then random bursts.
module two_queue_message_arbiter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tqma_pkg::*;

    localparam int QDEPTH      = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_OPS  = 600;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         Q_DEFERRED  = 0;
    localparam int         Q_IMMEDIATE = 1;

    typedef struct packed {
        logic [3:0]           pad;
        logic [1:0]           status;
        logic                 from_queue;
        logic [PAYLOAD_W-1:0] payload;
        logic [KIND_W-1:0]    kind;
        logic [ENTITY_W-1:0]  entity;
        logic                 out_valid;
    } outcome_t;

    typedef struct {
        logic [1:0]           mode;
        logic                 lock;
        logic [ENTITY_W-1:0]  entity;
        logic [KIND_W-1:0]    kind;
        logic [PAYLOAD_W-1:0] payload;
        bit                   typed;
        outcome_t             want;
    } stim_row_t;

    localparam outcome_t NO_DATA  = '0;
    localparam outcome_t POP_NONE = {4'd0, ST_POP_EMPTY, 1'b0, 32'd0, 8'd0, 16'd0, 1'b0};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    two_queue_message_arbiter #(.QUEUE_DEPTH(QDEPTH)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predictor state: index 0 deferred, 1 immediate (matches from_queue)
    entry_t            queue_store [2][QDEPTH];
    int                q_head  [2];
    int                q_tail  [2];
    int                q_count [2];
    logic [KIND_W-1:0] active_kind;

    outcome_t  awaited_results[$];
    stim_row_t directed_rows[$];

    bit quiet_stretch;
    int errors;
    int cycles;
    int n_checked, n_pushes, n_dropped, n_popped, n_from_imm, n_empty_pops;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     awaited_results.size());
            $display("[two_queue_message_arbiter] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= 30)
            $display("mismatch on %s: got %0h, expected %0h (result %0d)", what, got, want,
                     n_checked);
    endtask

    task automatic take_head(input int q, output entry_t msg);
        msg = queue_store[q][q_head[q]];
        q_head[q]++;
        q_count[q]--;
        // linear queue: pointers rewind only once it runs dry
        if (q_count[q] == 0) begin
            q_head[q] = 0;
            q_tail[q] = 0;
        end
    endtask

    task automatic arbitrate(input logic [1:0] mode, input logic lock, input entry_t msg,
                             output outcome_t res);
        int     q;
        entry_t popped;
        res = '0;
        case (mode) inside
            MODE_PUSH, MODE_PUSH_DEF: begin
                q = (mode == MODE_PUSH && lock) ? Q_IMMEDIATE : Q_DEFERRED;
                n_pushes++;
                if (q_tail[q] >= QDEPTH) begin
                    res.status = ST_DROPPED;
                    n_dropped++;
                end else begin
                    queue_store[q][q_tail[q]] = msg;
                    q_tail[q]++;
                    q_count[q]++;
                end
            end
            MODE_POP: begin
                if (q_count[Q_IMMEDIATE] == 0 && q_count[Q_DEFERRED] == 0) begin
                    res.status = ST_POP_EMPTY;
                    n_empty_pops++;
                end else begin
                    if (q_count[Q_IMMEDIATE] == 0) begin
                        take_head(Q_DEFERRED, popped);
                        active_kind = popped.kind;
                        q = Q_DEFERRED;
                    end else if (q_count[Q_DEFERRED] > 0 &&
                                 queue_store[Q_DEFERRED][q_head[Q_DEFERRED]].kind
                                 != active_kind) begin
                        take_head(Q_DEFERRED, popped);
                        q = Q_DEFERRED;
                    end else begin
                        take_head(Q_IMMEDIATE, popped);
                        q = Q_IMMEDIATE;
                        n_from_imm++;
                    end
                    res.out_valid  = 1'b1;
                    res.entity     = popped.entity;
                    res.kind       = popped.kind;
                    res.payload    = popped.payload;
                    res.from_queue = (q == Q_IMMEDIATE);
                    n_popped++;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_command(input stim_row_t row);
        int       gap;
        entry_t   msg;
        outcome_t res;
        gap = quiet_stretch ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.mode;
        s_tdata  <= {7'd0, row.payload, row.kind, row.entity, row.lock};
        do @(posedge aclk); while (!s_tready);
        msg.entity  = row.entity;
        msg.kind    = row.kind;
        msg.payload = row.payload;
        arbitrate(row.mode, row.lock, msg, res);
        awaited_results.push_back(row.typed ? row.want : res);
    endtask

    task automatic add_row(input logic [1:0] mode, input logic lock,
                           input logic [ENTITY_W-1:0] entity, input logic [KIND_W-1:0] kind,
                           input logic [PAYLOAD_W-1:0] payload, input bit typed,
                           input outcome_t want);
        stim_row_t row;
        row.mode    = mode;
        row.lock    = lock;
        row.entity  = entity;
        row.kind    = kind;
        row.payload = payload;
        row.typed   = typed;
        row.want    = want;
        directed_rows.push_back(row);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind();
        // a narrow pool makes the processing-type match happen often
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd254;
            3:       return KIND_NONE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // result side
    initial begin
        outcome_t got;
        outcome_t want;
        int       stall;
        m_tready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = quiet_stretch ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got = m_tdata;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected transfer", got, '0);
            end else begin
                want = awaited_results.pop_front();
                if (got.out_valid !== want.out_valid)
                    report_mismatch("out_valid", 64'(got.out_valid), 64'(want.out_valid));
                if (got.entity !== want.entity)
                    report_mismatch("out_entity", 64'(got.entity), 64'(want.entity));
                if (got.kind !== want.kind)
                    report_mismatch("out_kind", 64'(got.kind), 64'(want.kind));
                if (got.payload !== want.payload)
                    report_mismatch("out_payload", 64'(got.payload), 64'(want.payload));
                if (got.from_queue !== want.from_queue)
                    report_mismatch("from_queue", 64'(got.from_queue),
                                    64'(want.from_queue));
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.pad !== want.pad)
                    report_mismatch("tdata padding", 64'(got.pad), 64'(want.pad));
                n_checked++;
            end
        end
    end

    // command side and end of run
    initial begin
        stim_row_t row;
        int        ops;
        int        style;
        int        len;
        logic      fill_lock;
        logic [1:0] fill_mode;
        int        roll;

        quiet_stretch = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_PUSH;
        for (int q = 0; q < 2; q++) begin
            q_head[q]  = 0;
            q_tail[q]  = 0;
            q_count[q] = 0;
        end
        active_kind = KIND_NONE;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // pop on empty and unused mode right after reset
        add_row(MODE_POP,      1'b0, 16'h0000, 8'h00, 32'h0000_0000, 1, POP_NONE);
        add_row(MODE_UNUSED,   1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1, NO_DATA);
        // field extremes; type 255 into both queues
        add_row(MODE_PUSH,     1'b0, 16'hFFFF, 8'd254, 32'hFFFF_FFFF, 1, NO_DATA);
        add_row(MODE_PUSH_DEF, 1'b1, 16'h0000, 8'h00, 32'h0000_0000, 1, NO_DATA);
        add_row(MODE_PUSH,     1'b1, 16'h1234, 8'd254, 32'hA5A5_A5A5, 1, NO_DATA);
        add_row(MODE_PUSH,     1'b1, 16'h00FF, KIND_NONE, 32'h5A5A_5A5A, 1, NO_DATA);
        add_row(MODE_PUSH_DEF, 1'b0, 16'h8000, KIND_NONE, 32'h8000_0000, 1, NO_DATA);
        // deferred heads differ from the reset type, then a 255 head matches it
        add_row(MODE_POP,      1'b0, 16'h0000, 8'h00, 32'h0, 0, NO_DATA);
        add_row(MODE_POP,      1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 0, NO_DATA);
        add_row(MODE_POP,      1'b0, 16'h0000, 8'h00, 32'h0, 0, NO_DATA);
        add_row(MODE_POP,      1'b0, 16'h0000, 8'h00, 32'h0, 0, NO_DATA);
        add_row(MODE_POP,      1'b0, 16'h0000, 8'h00, 32'h0, 0, NO_DATA);
        add_row(MODE_POP,      1'b0, 16'h0000, 8'h00, 32'h0, 1, POP_NONE);
        // processing type taken from a deferred pop, then blocks the next deferred head
        add_row(MODE_PUSH,     1'b0, 16'h0001, 8'd7, 32'h0000_0001, 1, NO_DATA);
        add_row(MODE_POP,      1'b0, 16'h0000, 8'h00, 32'h0, 0, NO_DATA);
        add_row(MODE_PUSH_DEF, 1'b1, 16'h0003, 8'd7, 32'h0000_0003, 1, NO_DATA);
        add_row(MODE_PUSH,     1'b1, 16'h0002, 8'd9, 32'h0000_0002, 1, NO_DATA);
        add_row(MODE_POP,      1'b0, 16'h0000, 8'h00, 32'h0, 0, NO_DATA);
        add_row(MODE_POP,      1'b0, 16'h0000, 8'h00, 32'h0, 0, NO_DATA);
        add_row(MODE_UNUSED,   1'b0, 16'h5555, 8'h55, 32'h5555_5555, 1, NO_DATA);
        add_row(MODE_POP,      1'b1, 16'h0000, 8'h00, 32'h0, 1, POP_NONE);

        foreach (directed_rows[i]) send_command(directed_rows[i]);

        // random bursts: fills to capacity, mixed traffic, drains, raw noise
        ops = 0;
        while (ops < RANDOM_OPS) begin
            style = $urandom_range(0, 3);
            len   = $urandom_range(20, 90);
            quiet_stretch = ($urandom_range(0, 3) == 0);
            fill_lock = 1'($urandom_range(0, 1));
            fill_mode = $urandom_range(0, 1) ? MODE_PUSH : MODE_PUSH_DEF;
            if (style == 0) len = 75;
            for (int k = 0; k < len; k++) begin
                roll = $urandom_range(0, 99);
                row.lock    = 1'($urandom_range(0, 1));
                row.entity  = 16'($urandom_range(0, 65535));
                row.kind    = pick_kind();
                row.payload = $urandom();
                row.typed   = 0;
                row.want    = '0;
                case (style)
                    0: begin
                        row.mode = (roll < 88) ? fill_mode : MODE_POP;
                        row.lock = fill_lock;
                    end
                    1: row.mode = (roll < 40) ? MODE_PUSH :
                                  (roll < 60) ? MODE_PUSH_DEF :
                                  (roll < 96) ? MODE_POP : MODE_UNUSED;
                    2: row.mode = (roll < 80) ? MODE_POP :
                                  (roll < 90) ? MODE_PUSH : MODE_PUSH_DEF;
                    default: begin
                        row.mode = 2'($urandom_range(0, 3));
                        row.kind = 8'($urandom_range(0, 255));
                    end
                endcase
                send_command(row);
                if (row.mode != MODE_UNUSED) ops++;
            end
        end
        s_tvalid <= 1'b0;
        quiet_stretch = 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("checked %0d results: %0d pushes (%0d dropped at capacity), %0d pops",
                 n_checked, n_pushes, n_dropped, n_popped);
        $display("  %0d pops served from the immediate queue, %0d pops with both queues empty",
                 n_from_imm, n_empty_pops);
        if (errors == 0) begin
            $display("[two_queue_message_arbiter] OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("[two_queue_message_arbiter] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/tqma_pkg.sv
sv/tqma_queue.sv
sv/two_queue_message_arbiter.sv
test/two_queue_message_arbiter_test.sv
